// ===== design/cc_pkg.sv =====
// ----------------------------------------------------------------------------
// cc_pkg
// Shared types, constants and quarter round helpers for the chacha20 block
// function.
// ----------------------------------------------------------------------------
`default_nettype none

package cc_pkg;

  localparam int WORD_W     = 32;
  localparam int WORD_COUNT = 16;
  localparam int IDX_W      = $clog2(WORD_COUNT);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_ROUND = 3'b010,
    ST_OUT   = 3'b100
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic rnd;
    logic diag;
    logic second;
    logic emit;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  function automatic word_t rotl(word_t v, int unsigned s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

  // half of a quarter round: first half rotates by 16 and 12, second by 8 and 7
  function automatic quad_t qr_half(quad_t q, logic second);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t x;
    word_t y;
    quad_t res;
    a = q.a + q.b;
    x = q.d ^ a;
    d = second ? rotl(x, 8) : rotl(x, 16);
    c = q.c + d;
    y = q.b ^ c;
    b = second ? rotl(y, 7) : rotl(y, 12);
    res.a = a;
    res.b = b;
    res.c = c;
    res.d = d;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/cc_in_if.sv =====
// ----------------------------------------------------------------------------
// cc_in_if
// Request channel carrying one chacha state word per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] state_word;

  modport source (output valid, output state_word, input ready);
  modport sink   (input valid, input state_word, output ready);
endinterface

`default_nettype wire

// ===== design/cc_out_if.sv =====
// ----------------------------------------------------------------------------
// cc_out_if
// Result channel carrying one keystream word per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_word;
  logic        last_word;

  modport source (output valid, output key_word, output last_word, input ready);
  modport sink   (input valid, input key_word, input last_word, output ready);
endinterface

`default_nettype wire

// ===== design/cc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cc_ctrl
// Load, round and output sequencer; drives the datapath by command struct.
// ----------------------------------------------------------------------------
`default_nettype none

module cc_ctrl
  import cc_pkg::*;
#(
  parameter int ROUND_COUNT = 20
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  localparam int STEPS  = 4 * ((ROUND_COUNT + 1) / 2);
  localparam int STEP_W = $clog2(STEPS);

  state_t              state_r, state_nxt;
  idx_t                cnt_r, cnt_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                load;
  logic                emit;
  logic                cnt_last;
  logic                step_last;

  assign in_ready  = (state_r == ST_LOAD);
  assign load      = in_ready && in_valid;
  assign emit      = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign cnt_last  = (cnt_r == IDX_W'(WORD_COUNT - 1));
  assign step_last = (step_r == STEP_W'(STEPS - 1));
  assign out_valid = out_valid_r;

  assign cmd.load   = load;
  assign cmd.rnd    = (state_r == ST_ROUND);
  assign cmd.diag   = step_r[1];
  assign cmd.second = step_r[0];
  assign cmd.emit   = emit;
  assign cmd.last   = cnt_last;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
    case (state_r)
      ST_LOAD: begin
        if (load) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_last) begin
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        step_nxt = step_r + 1'b1;
        if (step_last) begin
          step_nxt  = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (emit) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_last) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/cc_datapath.sv =====
// ----------------------------------------------------------------------------
// cc_datapath
// Original and working word shift lines, four half quarter round lanes and
// the output register with the final addition.
// ----------------------------------------------------------------------------
`default_nettype none

module cc_datapath
  import cc_pkg::*;
(
  input  logic    clk,
  input  dp_cmd_t cmd,
  input  word_t   in_word,
  output word_t   key_word,
  output logic    last_word
);

  word_t orig_r [WORD_COUNT];
  word_t work_r [WORD_COUNT];
  word_t work_nxt [WORD_COUNT];
  word_t key_r;
  logic  last_r;

  assign key_word  = key_r;
  assign last_word = last_r;

  // four lanes, column or diagonal selection by fixed taps
  always_comb begin
    quad_t q_col;
    quad_t q_dia;
    quad_t q_res;
    for (int k = 0; k < WORD_COUNT; k++) begin
      work_nxt[k] = work_r[k];
    end
    for (int i = 0; i < 4; i++) begin
      q_col.a = work_r[i];
      q_col.b = work_r[4 + i];
      q_col.c = work_r[8 + i];
      q_col.d = work_r[12 + i];
      q_dia.a = work_r[i];
      q_dia.b = work_r[4 + ((i + 1) & 3)];
      q_dia.c = work_r[8 + ((i + 2) & 3)];
      q_dia.d = work_r[12 + ((i + 3) & 3)];
      q_res   = qr_half(cmd.diag ? q_dia : q_col, cmd.second);
      if (cmd.diag) begin
        work_nxt[i]                  = q_res.a;
        work_nxt[4 + ((i + 1) & 3)]  = q_res.b;
        work_nxt[8 + ((i + 2) & 3)]  = q_res.c;
        work_nxt[12 + ((i + 3) & 3)] = q_res.d;
      end else begin
        work_nxt[i]      = q_res.a;
        work_nxt[4 + i]  = q_res.b;
        work_nxt[8 + i]  = q_res.c;
        work_nxt[12 + i] = q_res.d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < WORD_COUNT - 1; k++) begin
        orig_r[k] <= orig_r[k + 1];
        work_r[k] <= work_r[k + 1];
      end
      orig_r[WORD_COUNT - 1] <= in_word;
      work_r[WORD_COUNT - 1] <= in_word;
    end else if (cmd.emit) begin
      for (int k = 0; k < WORD_COUNT - 1; k++) begin
        orig_r[k] <= orig_r[k + 1];
        work_r[k] <= work_r[k + 1];
      end
      key_r  <= work_r[0] + orig_r[0];
      last_r <= cmd.last;
    end else if (cmd.rnd) begin
      for (int k = 0; k < WORD_COUNT; k++) begin
        work_r[k] <= work_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/chacha20_block_function.sv =====
// ----------------------------------------------------------------------------
// chacha20_block_function
// ChaCha block function: sixteen state words in, rounds, sixteen keystream
// words out, each the permuted word plus the original word.
//
//   channel   dir   payload                   transfer
//   in_ch     in    state_word[31:0]          valid && ready
//   out_ch    out   key_word[31:0], last_word valid && ready
//
// A block loads 16 words, runs 4 * ((ROUND_COUNT + 1) / 2) round steps
// (one half quarter round on four lanes per cycle), then emits 16 words.
// Synchronous active-low reset returns the sequencer to loading word 0.
// in_ch.ready is high only while loading; output stalls hold the sequencer
// in its output phase behind a single output register.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_block_function
  import cc_pkg::*;
#(
  parameter int ROUND_COUNT = 20
) (
  input  logic     clk,
  input  logic     rst_n,
  cc_in_if.sink    in_ch,
  cc_out_if.source out_ch
);

  dp_cmd_t cmd;
  logic    in_ready;
  logic    out_valid;
  word_t   key_word;
  logic    last_word;

  cc_ctrl #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .out_ready(out_ch.ready),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  cc_datapath u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_word  (in_ch.state_word),
    .key_word (key_word),
    .last_word(last_word)
  );

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.key_word  = key_word;
  assign out_ch.last_word = last_word;

  a_no_load_and_emit : assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.emit))
    else $error("load and emit in the same cycle");

  a_round_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rnd |-> (!in_ready && !cmd.emit))
    else $error("round step overlaps load or output");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ch.ready) |=>
      (out_valid && $stable(key_word) && $stable(last_word)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

// ===== verif/tb_chacha20_pkg.sv =====
// ----------------------------------------------------------------------------
// tb_chacha20_pkg
// Keystream scoreboard for the chacha20 block function testbench. It collects
// the state words of each accepted block, computes the sixteen keystream
// words on its own copy of the state and checks the results in order.
// ----------------------------------------------------------------------------
`default_nettype none

package tb_chacha20_pkg;

  import cc_pkg::*;

  typedef struct {
    word_t key;
    logic  last;
  } key_exp_t;

  class keystream_scoreboard;
    int unsigned errors;
    int unsigned double_rounds;
    int unsigned fill;
    int unsigned checked;
    word_t       loaded_words[WORD_COUNT];
    word_t       mix[WORD_COUNT];
    key_exp_t    expected_keys[$];

    function new(int unsigned rounds);
      // an odd round count still runs a whole double round
      double_rounds = (rounds + 1) / 2;
      errors        = 0;
      fill          = 0;
      checked       = 0;
    endfunction

    function word_t spin(word_t v, int unsigned s);
      return (v << s) | (v >> (WORD_W - s));
    endfunction

    function void mix_quarter(int a, int b, int c, int d);
      mix[a] = mix[a] + mix[b]; mix[d] = spin(mix[d] ^ mix[a], 16);
      mix[c] = mix[c] + mix[d]; mix[b] = spin(mix[b] ^ mix[c], 12);
      mix[a] = mix[a] + mix[b]; mix[d] = spin(mix[d] ^ mix[a], 8);
      mix[c] = mix[c] + mix[d]; mix[b] = spin(mix[b] ^ mix[c], 7);
    endfunction

    function void make_keystream();
      key_exp_t e;
      for (int i = 0; i < WORD_COUNT; i++) mix[i] = loaded_words[i];
      for (int r = 0; r < double_rounds; r++) begin
        mix_quarter(0, 4, 8, 12);
        mix_quarter(1, 5, 9, 13);
        mix_quarter(2, 6, 10, 14);
        mix_quarter(3, 7, 11, 15);
        mix_quarter(0, 5, 10, 15);
        mix_quarter(1, 6, 11, 12);
        mix_quarter(2, 7, 8, 13);
        mix_quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < WORD_COUNT; i++) begin
        e.key  = mix[i] + loaded_words[i];
        e.last = (i == WORD_COUNT - 1);
        expected_keys.push_back(e);
      end
    endfunction

    function void note_word(word_t w);
      loaded_words[fill] = w;
      fill++;
      if (fill == WORD_COUNT) begin
        fill = 0;
        make_keystream();
      end
    endfunction

    function int unsigned pending();
      return expected_keys.size();
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_key(word_t key, logic last);
      key_exp_t e;
      if (expected_keys.size() == 0) begin
        report($sformatf("unexpected key word %08h last %0b", key, last));
      end else begin
        e = expected_keys.pop_front();
        if (key !== e.key)
          report($sformatf("key word %0d: got %08h want %08h", checked, key, e.key));
        if (last !== e.last)
          report($sformatf("key word %0d: last got %0b want %0b", checked, last, e.last));
      end
      checked++;
    endtask
  endclass

endpackage

`default_nettype wire

// ===== verif/tb_chacha20_block_function.sv =====
// ----------------------------------------------------------------------------
// tb_chacha20_block_function
// Drives whole chacha states into the block function, one word per request,
// under several sender idle and receiver stall mixes, and checks every
// keystream word and its last flag against the scoreboard's own prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_chacha20_block_function;

  import cc_pkg::*;
  import tb_chacha20_pkg::*;

  localparam int          ROUNDS     = 20;
  localparam int          RAND_SETS  = 5;
  localparam int unsigned IDLE_LIMIT = 4000;

  localparam word_t SIGMA[4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

  localparam word_t EDGE_WORDS[WORD_COUNT] = '{
    32'h00000000, 32'hffffffff, 32'h00000001, 32'h80000000,
    32'h7fffffff, 32'hfffffffe, 32'ha5a5a5a5, 32'h5a5a5a5a,
    32'h00000000, 32'h00000000, 32'hffffffff, 32'hffffffff,
    32'h00000001, 32'h09000000, 32'h4a000000, 32'h00000000
  };

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned idle_cycles;

  keystream_scoreboard sb;

  cc_in_if  in_ch();
  cc_out_if out_ch();

  chacha20_block_function #(.ROUND_COUNT(ROUNDS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_word(in_ch.state_word);
      if (out_ch.valid && out_ch.ready) sb.check_key(out_ch.key_word, out_ch.last_word);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(31);
      3:       return ~(word_t'(1) << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  task send_word(word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.state_word <= w;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task send_random_state();
    bit with_sigma;
    with_sigma = 1'($urandom_range(1));
    for (int i = 0; i < WORD_COUNT; i++)
      send_word((with_sigma && i < 4) ? SIGMA[i] : pick_word());
  endtask

  // hold off new requests until every keystream word is back
  task wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    sb               = new(ROUNDS);
    idle_pct         = 0;
    rst_n            <= 1'b0;
    stall_pct        <= 0;
    in_ch.valid      <= 1'b0;
    in_ch.state_word <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (EDGE_WORDS[i]) send_word(EDGE_WORDS[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 58; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 58; end
        default: begin idle_pct = 33; stall_pct <= 33; end
      endcase
      for (int n = phase; n < RAND_SETS; n += 4) send_random_state();
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
